// ===== src/sib_pkg.sv =====
`default_nettype none

package sib_pkg;

  // Width of one stored value
  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] value_t;

endpackage

`default_nettype wire

// ===== src/sib_store.sv =====
`default_nettype none

// Entry store: one write port, one read port, registered read data.
module sib_store #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire sib_pkg::value_t          wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output sib_pkg::value_t               rdata
);

  sib_pkg::value_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_insertion_buffer_top.sv =====
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       to block   in_valid/in_stall  new_value
// out      from block out_valid/out_stall entry_value, last_entry, dropped_full
//
// The dump emits the list after the insert, one result per cycle while the output
// does not stall, set by the single read port of the entry store; the first result
// waits for the registered first read. Insertion runs during the dump: each entry
// is read once, and from the insert point on, entries are written back one slot
// higher. Reset empties the list (count to zero); the store is never cleared.
// A stall on the output freezes the scan; the input stalls while a dump runs.
module sorted_insertion_buffer_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire sib_pkg::value_t new_value,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output sib_pkg::value_t      entry_value,
  output logic                 last_entry,
  output logic                 dropped_full
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Control state
  logic          busy;
  logic [CW-1:0] count;
  logic [CW-1:0] cnt;
  logic [CW-1:0] j;
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic          full_r;
  logic          inserted;
  // Payload
  sib_pkg::value_t new_val;
  sib_pkg::value_t carry;

  // Store interface
  logic            we;
  logic [AW-1:0]   waddr;
  sib_pkg::value_t wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  sib_pkg::value_t rdata;

  sib_store #(.DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic            in_acc;
  logic            slot_free;
  logic            at_end;
  logic            step;
  logic [CW-1:0]   total;
  logic [CW-1:0]   j_inc;
  logic            last;
  logic            take_new;
  sib_pkg::value_t emit_val;

  // No item is taken while reset is held
  assign in_stall  = busy || rst;
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Position j beyond the old list needs no read (append slot)
  assign at_end = (j == cnt);
  assign step   = busy && slot_free && (at_end ? 1'b1 : pend);
  assign total  = full_r ? cnt : cnt + CW'(1);
  assign j_inc  = j + CW'(1);
  assign last   = (j_inc == total);

  // Merge: new value goes ahead of the first entry not smaller
  assign take_new = !full_r && !inserted && (at_end || (new_val <= rdata));

  always_comb begin
    we       = 1'b0;
    wdata    = carry;
    emit_val = rdata;
    if (take_new) begin
      emit_val = new_val;
      wdata    = new_val;
      we       = step;
    end else if (inserted) begin
      emit_val = carry;
      we       = step;
    end
  end
  assign waddr = j[AW-1:0];

  // Read one entry ahead of consumption
  assign re    = busy && (rd_idx < cnt) && (!pend || (step && !at_end));
  assign raddr = rd_idx[AW-1:0];

  // Scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      cnt      <= '0;
      j        <= '0;
      rd_idx   <= '0;
      pend     <= 1'b0;
      full_r   <= 1'b0;
      inserted <= 1'b0;
    end else begin
      if (in_acc) begin
        busy     <= 1'b1;
        cnt      <= count;
        j        <= '0;
        rd_idx   <= '0;
        pend     <= 1'b0;
        full_r   <= (count >= CAP_C);
        inserted <= 1'b0;
      end else begin
        if (re) begin
          rd_idx <= rd_idx + CW'(1);
          pend   <= 1'b1;
        end else if (step && !at_end) begin
          pend <= 1'b0;
        end
        if (step) begin
          j <= j_inc;
          if (take_new) begin
            inserted <= 1'b1;
          end
          if (last) begin
            busy  <= 1'b0;
            count <= total;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      new_val <= new_value;
    end
    if (step) begin
      carry <= rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      entry_value  <= emit_val;
      last_entry   <= last;
      dropped_full <= full_r;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    re |-> (rd_idx < cnt))
    else $error("read beyond stored entries");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    we |-> !full_r)
    else $error("store written while list full");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> !busy && out_valid && last_entry)
    else $error("dump did not end on last item");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> busy && (j == '0))
    else $error("accepted item did not start a dump");

endmodule

`default_nettype wire
